// ----- hw/rtl/pfact_pkg.sv -----
// Shared constants for the prime factorizer: field widths, result limit and
// the first trial divisors of the 6k-1 / 6k+1 candidate walk.
// No dependencies.
package pfact_pkg;

    // Default width of the signed input word.
    localparam int VALUE_WIDTH_DEF = 32;

    // Widths of the result word fields.
    localparam int PRIME_WIDTH = 31;
    localparam int EXP_WIDTH   = 5;

    // Largest number of result words for one input word.
    localparam int MAX_RESULTS = 9;

    // Trial divisors: 2, 3, then 5 and every 6k-1 / 6k+1 after it.
    localparam int CAND_FIRST  = 2;
    localparam int CAND_SECOND = 3;
    localparam int CAND_THIRD  = 5;
    localparam int STEP_SHORT  = 2;
    localparam int STEP_LONG   = 4;

endpackage

// ----- hw/rtl/prime_factorizer.sv -----
// Prime factorizer by trial division with one shared restoring divider.
// Depends on pfact_pkg for field widths, the result limit and candidate constants.
//
// One input word is taken while the block is idle. A value of 1 or less (or
// negative) gives one word marked empty. Otherwise the block gives the
// prime factors in ascending order as (prime, exponent) words, the last one
// marked, each carrying whether the input itself is prime. The candidates
// 2, 3, 5, 7, 11, 13, ... are tried in turn by one restoring divider that
// produces one quotient bit per cycle, so each trial division runs through
// a load, one divide step per magnitude bit and an evaluation, plus a
// record step for each factor found. The walk ends once the quotient
// drops below the candidate, so an input n takes about m / 3 trials, where
// m is the larger of the second largest prime factor of n and the square
// root of the largest one (the largest itself when it repeats, the square
// root of n when n is prime): roughly 15,500 trials for a prime near 2^31.
// The divider is the only arithmetic unit; a finished word waits in the
// output register while the block keeps working, and the block stalls
// only when it must hand over a new word before the previous one is taken.
module prime_factorizer
    import pfact_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [PRIME_WIDTH-1:0]        o_prime_factor,
    output logic [EXP_WIDTH-1:0]          o_exponent,
    output logic                          o_empty_res,
    output logic                          o_input_is_prime,
    output logic                          o_last
);

    // Magnitude width, candidate width (holds a little beyond the square
    // root of the largest magnitude), divide step counter, result counter.
    localparam int NW   = VALUE_WIDTH - 1;
    localparam int CW   = (NW + 1) / 2 + 1;
    localparam int BW   = $clog2(NW);
    localparam int CNTW = $clog2(MAX_RESULTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMPTY = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_REC   = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [NW-1:0]        r_n, n_n;
    logic [NW-1:0]        r_orig, n_orig;
    logic [CW-1:0]        r_cand, n_cand;
    logic                 r_step4, n_step4;
    logic [EXP_WIDTH-1:0] r_exp, n_exp;
    logic                 r_hit, n_hit;
    logic                 r_stop, n_stop;
    logic                 r_tail, n_tail;
    logic [CNTW-1:0]      r_cnt, n_cnt;
    logic                 r_pvalid, n_pvalid;
    logic [NW-1:0]        r_pprime, n_pprime;
    logic [EXP_WIDTH-1:0] r_pexp, n_pexp;
    logic [NW-1:0]        r_quo, n_quo;
    logic [CW-1:0]        r_rem, n_rem;
    logic [BW-1:0]        r_bit, n_bit;

    logic                 r_out_valid, n_out_valid;
    logic [NW-1:0]        r_out_prime, n_out_prime;
    logic [EXP_WIDTH-1:0] r_out_exp, n_out_exp;
    logic                 r_out_empty, n_out_empty;
    logic                 r_out_isprime, n_out_isprime;
    logic                 r_out_last, n_out_last;

    logic                 in_bad;
    logic                 out_free;
    logic [CW:0]          rem_sh;
    logic                 rem_ge;
    logic [CW:0]          rem_sub;
    logic [CW-1:0]        cand_next;
    logic                 step4_next;
    logic                 quo_lt_cand;
    logic [NW-1:0]        rec_prime;
    logic [EXP_WIDTH-1:0] rec_exp;
    logic                 run_full;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    // Negative values, zero and one have no factors.
    assign in_bad = i_value[VALUE_WIDTH-1] || (i_value[NW-1:0] <= NW'(1));

    // One restoring divide step: shift in the next dividend bit, subtract
    // the candidate when it fits.
    assign rem_sh  = {r_rem, r_quo[NW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_cand});
    assign rem_sub = rem_sh - {1'b0, r_cand};

    // Quotient below the candidate means candidate squared exceeds the cofactor.
    assign quo_lt_cand = (r_quo < NW'(r_cand));

    // Next trial divisor: 2, 3, 5, then alternately plus two and plus four.
    always_comb begin
        if (r_cand == CW'(CAND_FIRST)) begin
            cand_next  = CW'(CAND_SECOND);
            step4_next = 1'b0;
        end else if (r_cand == CW'(CAND_SECOND)) begin
            cand_next  = CW'(CAND_THIRD);
            step4_next = 1'b0;
        end else begin
            cand_next  = r_cand + (r_step4 ? CW'(STEP_LONG) : CW'(STEP_SHORT));
            step4_next = !r_step4;
        end
    end

    // Factor to record: the finished candidate, or the leftover cofactor.
    assign rec_prime = r_tail ? r_n : NW'(r_cand);
    assign rec_exp   = r_tail ? EXP_WIDTH'(1) : r_exp;
    assign run_full  = r_pvalid && (r_cnt == CNTW'(MAX_RESULTS - 2));

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_orig        = r_orig;
        n_cand        = r_cand;
        n_step4       = r_step4;
        n_exp         = r_exp;
        n_hit         = r_hit;
        n_stop        = r_stop;
        n_tail        = r_tail;
        n_cnt         = r_cnt;
        n_pvalid      = r_pvalid;
        n_pprime      = r_pprime;
        n_pexp        = r_pexp;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_bit         = r_bit;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_prime   = r_out_prime;
        n_out_exp     = r_out_exp;
        n_out_empty   = r_out_empty;
        n_out_isprime = r_out_isprime;
        n_out_last    = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n      = i_value[NW-1:0];
                    n_orig   = i_value[NW-1:0];
                    n_cand   = CW'(CAND_FIRST);
                    n_step4  = 1'b0;
                    n_exp    = '0;
                    n_hit    = 1'b0;
                    n_stop   = 1'b0;
                    n_tail   = 1'b0;
                    n_cnt    = '0;
                    n_pvalid = 1'b0;
                    n_state  = in_bad ? S_EMPTY : S_START;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_prime   = '0;
                    n_out_exp     = '0;
                    n_out_empty   = 1'b1;
                    n_out_isprime = 1'b0;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_START: begin
                n_quo   = r_n;
                n_rem   = '0;
                n_bit   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[NW-2:0], rem_ge};
                n_rem = rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                n_bit = r_bit + BW'(1);
                if (r_bit == BW'(NW - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_rem == '0) begin
                    // Candidate divides: keep the quotient and try it again.
                    n_n     = r_quo;
                    n_exp   = r_exp + EXP_WIDTH'(1);
                    n_hit   = 1'b1;
                    n_state = S_START;
                end else if (r_hit) begin
                    n_stop  = quo_lt_cand;
                    n_state = S_REC;
                end else if (quo_lt_cand) begin
                    if (r_n > NW'(1)) begin
                        n_tail  = 1'b1;
                        n_state = S_REC;
                    end else begin
                        n_state = S_FINAL;
                    end
                end else begin
                    n_cand  = cand_next;
                    n_step4 = step4_next;
                    n_state = S_START;
                end
            end
            S_REC: begin
                if (!r_pvalid || out_free) begin
                    // Hand the held factor on; it is not the last one.
                    if (r_pvalid) begin
                        n_out_valid   = 1'b1;
                        n_out_prime   = r_pprime;
                        n_out_exp     = r_pexp;
                        n_out_empty   = 1'b0;
                        n_out_isprime = 1'b0;
                        n_out_last    = 1'b0;
                        n_cnt         = r_cnt + CNTW'(1);
                    end
                    n_pvalid = 1'b1;
                    n_pprime = rec_prime;
                    n_pexp   = rec_exp;
                    n_exp    = '0;
                    n_hit    = 1'b0;
                    if (run_full || r_tail) begin
                        n_state = S_FINAL;
                    end else if (r_stop) begin
                        if (r_n > NW'(1)) begin
                            n_tail  = 1'b1;
                            n_state = S_REC;
                        end else begin
                            n_state = S_FINAL;
                        end
                    end else begin
                        n_cand  = cand_next;
                        n_step4 = step4_next;
                        n_state = S_START;
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_prime   = r_pprime;
                    n_out_exp     = r_pexp;
                    n_out_empty   = 1'b0;
                    n_out_isprime = (r_cnt == '0) && (r_pexp == EXP_WIDTH'(1))
                                    && (r_pprime == r_orig);
                    n_out_last    = 1'b1;
                    n_pvalid      = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pvalid    <= 1'b0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_stop      <= 1'b0;
            r_tail      <= 1'b0;
            r_step4     <= 1'b0;
            r_bit       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pvalid    <= n_pvalid;
            r_cnt       <= n_cnt;
            r_hit       <= n_hit;
            r_stop      <= n_stop;
            r_tail      <= n_tail;
            r_step4     <= n_step4;
            r_bit       <= n_bit;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_n           <= n_n;
        r_orig        <= n_orig;
        r_cand        <= n_cand;
        r_exp         <= n_exp;
        r_pprime      <= n_pprime;
        r_pexp        <= n_pexp;
        r_quo         <= n_quo;
        r_rem         <= n_rem;
        r_out_prime   <= n_out_prime;
        r_out_exp     <= n_out_exp;
        r_out_empty   <= n_out_empty;
        r_out_isprime <= n_out_isprime;
        r_out_last    <= n_out_last;
    end

    // Output word.
    assign o_out_valid      = r_out_valid;
    assign o_prime_factor   = PRIME_WIDTH'(r_out_prime);
    assign o_exponent       = r_out_exp;
    assign o_empty_res      = r_out_empty;
    assign o_input_is_prime = r_out_isprime;
    assign o_last           = r_out_last;

endmodule
